// ----- src/gbos_pkg.sv -----
// Shared types and constants of the greedy box overlap suppression block.
package gbos_pkg;

    localparam int DEF_MAX_BOXES = 1024;
    localparam int DEF_MAX_KEEP  = 64;

    localparam logic [1:0] CFG_SCORE_THR = 2'd0;
    localparam logic [1:0] CFG_OVL_THR   = 2'd1;
    localparam logic [1:0] CFG_MAX_CAND  = 2'd2;

    localparam logic signed [16:0] RST_SCORE_THR = -17'sd1;
    localparam logic [16:0]        RST_OVL_THR   = 17'd29491;
    localparam logic signed [11:0] RST_MAX_CAND  = -12'sd1;

    typedef enum logic [4:0] {
        ST_LOAD,
        ST_SORT_INIT,
        ST_SORT_CHK,
        ST_SORT_SC,
        ST_SORT_J,
        ST_SORT_RO,
        ST_SORT_RS,
        ST_CAP,
        ST_WALK_CHK,
        ST_WALK_RO,
        ST_WALK_RB,
        ST_WALK_AREA,
        ST_PAIR_CHK,
        ST_PAIR_RK,
        ST_PAIR_RB,
        ST_PAIR_W1,
        ST_PAIR_W2,
        ST_PAIR_W3,
        ST_PAIR_DEC,
        ST_OUT_INIT,
        ST_OUT_RK,
        ST_OUT_RS,
        ST_OUT_LD,
        ST_OUT_WAIT
    } state_t;

    typedef struct packed {
        logic load;
        logic sort_init;
        logic rd_score_i;
        logic sort_take;
        logic i_inc;
        logic ins_i;
        logic rd_ord_jm1;
        logic rd_score_ord;
        logic shift;
        logic cap;
        logic rd_ord_i;
        logic rd_box_ord;
        logic cand_latch;
        logic jk_clr;
        logic rd_kl;
        logic rd_box_kl;
        logic jk_inc;
        logic keep;
        logic set_over;
        logic out_none;
        logic rd_score_kl;
        logic out_load;
        logic clear_run;
    } cmd_t;

    typedef struct packed {
        logic in_last;
        logic all_loaded;
        logic score_pass;
        logic j_zero;
        logic score_less;
        logic walk_done;
        logic kept_all;
        logic kept_full;
        logic pair_ok;
        logic kept_zero;
        logic out_last;
    } sts_t;

endpackage

// ----- src/gbos_if.sv -----
// Handshake channels of the block: boxes in, results out, register writes.
interface gbos_box_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] box_xmin;
    logic signed [15:0] box_ymin;
    logic signed [15:0] box_xmax;
    logic signed [15:0] box_ymax;
    logic [15:0]        score;
    logic               last_box;

    modport source(output valid, box_xmin, box_ymin, box_xmax, box_ymax, score, last_box,
                   input ready);
    modport sink(input valid, box_xmin, box_ymin, box_xmax, box_ymax, score, last_box,
                 output ready);
endinterface

interface gbos_res_if;
    logic        valid;
    logic        ready;
    logic [9:0]  kept_index;
    logic [15:0] kept_score;
    logic        none_kept;
    logic        overflow;
    logic        last_result;

    modport source(output valid, kept_index, kept_score, none_kept, overflow, last_result,
                   input ready);
    modport sink(input valid, kept_index, kept_score, none_kept, overflow, last_result,
                 output ready);
endinterface

interface gbos_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [16:0] data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

// ----- src/gbos_dp.sv -----
// Datapath: box stores, candidate sort, overlap arithmetic and result register.
module gbos_dp #(
    parameter int MAX_BOXES = 1024,
    parameter int MAX_KEEP  = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  gbos_pkg::cmd_t     cmd,
    output gbos_pkg::sts_t     sts,
    input  logic signed [15:0] box_xmin,
    input  logic signed [15:0] box_ymin,
    input  logic signed [15:0] box_xmax,
    input  logic signed [15:0] box_ymax,
    input  logic [15:0]        score,
    input  logic               last_box,
    input  logic               cfg_wr,
    input  logic [1:0]         cfg_index,
    input  logic [16:0]        cfg_data,
    output logic [9:0]         kept_index,
    output logic [15:0]        kept_score,
    output logic               none_kept,
    output logic               overflow,
    output logic               last_result
);
    import gbos_pkg::*;

    localparam int AW   = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int CW   = $clog2(MAX_BOXES + 1);
    localparam int KW   = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
    localparam int KCW  = $clog2(MAX_KEEP + 1);
    localparam int CMPW = (CW > 11) ? CW : 11;

    logic [63:0]    box_mem   [MAX_BOXES];
    logic [15:0]    score_mem [MAX_BOXES];
    logic [AW-1:0]  order_mem [MAX_BOXES];
    logic [AW-1:0]  kl_mem    [MAX_KEEP];

    logic [63:0]    box_q_reg;
    logic [15:0]    score_q_reg;
    logic [AW-1:0]  order_q_reg;
    logic [AW-1:0]  kl_q_reg;

    logic signed [16:0] score_thr_reg;
    logic [16:0]        ovl_thr_reg;
    logic signed [11:0] max_cand_reg;

    logic [CW-1:0]  loaded_reg, i_reg, j_reg, cc_reg;
    logic           load_over_reg, over_reg;
    logic [15:0]    si_reg;
    logic [KCW-1:0] jk_reg, kept_reg;
    logic [AW-1:0]  cand_idx_reg;
    logic [63:0]    cand_reg;

    logic           pass_g_reg;
    logic [15:0]    iw_reg, ih_reg, bw_reg, bh_reg;
    logic [31:0]    area_a_reg, area_b_reg, inter_reg;
    logic [32:0]    uni_reg;
    logic [33:0]    plo_reg;
    logic [32:0]    phi_reg;

    logic [9:0]     out_idx_reg;
    logic [15:0]    out_score_reg;
    logic           out_none_reg, out_over_reg, out_last_reg;

    logic           full;
    logic           wr_box;
    logic [CW-1:0]  jm1;
    logic [AW-1:0]  score_raddr, order_raddr, box_raddr;
    logic           score_ren, order_ren, box_ren;
    logic [AW-1:0]  order_wdata;
    logic [KCW-1:0] jk_plus1;

    logic signed [15:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
    logic signed [15:0] ix0, iy0, ix1, iy1;
    logic signed [16:0] iw, ih, bwd, bhd, awd, ahd;
    logic               disj, b_inv, a_inv;
    logic [50:0]        lhs, rhs;

    assign full   = (loaded_reg == CW'(MAX_BOXES));
    assign wr_box = cmd.load && !full;
    assign jm1    = j_reg - CW'(1);
    assign jk_plus1 = jk_reg + KCW'(1);

    always_comb
    begin
        score_raddr = kl_q_reg;
        if (cmd.rd_score_i)
            score_raddr = i_reg[AW-1:0];
        else if (cmd.rd_score_ord)
            score_raddr = order_q_reg;
    end
    assign score_ren   = cmd.rd_score_i || cmd.rd_score_ord || cmd.rd_score_kl;
    assign order_raddr = cmd.rd_ord_jm1 ? jm1[AW-1:0] : i_reg[AW-1:0];
    assign order_ren   = cmd.rd_ord_jm1 || cmd.rd_ord_i;
    assign box_raddr   = cmd.rd_box_ord ? order_q_reg : kl_q_reg;
    assign box_ren     = cmd.rd_box_ord || cmd.rd_box_kl;
    assign order_wdata = cmd.shift ? order_q_reg : i_reg[AW-1:0];

    // Store memories, one write and one registered read each.
    always_ff @(posedge clk)
    begin
        if (wr_box)
        begin
            box_mem[loaded_reg[AW-1:0]] <= {box_xmin, box_ymin, box_xmax, box_ymax};
        end
        if (box_ren)
        begin
            box_q_reg <= box_mem[box_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_box)
        begin
            score_mem[loaded_reg[AW-1:0]] <= score;
        end
        if (score_ren)
        begin
            score_q_reg <= score_mem[score_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ins_i || cmd.shift)
        begin
            order_mem[j_reg[AW-1:0]] <= order_wdata;
        end
        if (order_ren)
        begin
            order_q_reg <= order_mem[order_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.keep)
        begin
            kl_mem[kept_reg[KW-1:0]] <= cand_idx_reg;
        end
        if (cmd.rd_kl)
        begin
            kl_q_reg <= kl_mem[jk_reg[KW-1:0]];
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            score_thr_reg <= RST_SCORE_THR;
            ovl_thr_reg   <= RST_OVL_THR;
            max_cand_reg  <= RST_MAX_CAND;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_index)
                CFG_SCORE_THR: score_thr_reg <= cfg_data;
                CFG_OVL_THR:   ovl_thr_reg   <= cfg_data;
                CFG_MAX_CAND:  max_cand_reg  <= cfg_data[11:0];
                default: ;
            endcase
        end
    end

    // Counters and run flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loaded_reg    <= '0;
            load_over_reg <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            cc_reg        <= '0;
            jk_reg        <= '0;
            kept_reg      <= '0;
            over_reg      <= 1'b0;
        end
        else
        begin
            if (cmd.clear_run)
            begin
                loaded_reg    <= '0;
                load_over_reg <= 1'b0;
            end
            else if (wr_box)
                loaded_reg <= loaded_reg + CW'(1);
            else if (cmd.load)
                load_over_reg <= 1'b1;

            if (cmd.sort_init || cmd.cap)
                i_reg <= '0;
            else if (cmd.i_inc || cmd.ins_i || cmd.keep)
                i_reg <= i_reg + CW'(1);

            if (cmd.sort_take)
                j_reg <= cc_reg;
            else if (cmd.shift)
                j_reg <= jm1;

            if (cmd.sort_init)
                cc_reg <= '0;
            else if (cmd.ins_i)
                cc_reg <= cc_reg + CW'(1);
            else if (cmd.cap && !max_cand_reg[11]
                     && (CMPW'(max_cand_reg[10:0]) < CMPW'(cc_reg)))
                cc_reg <= CW'(max_cand_reg[10:0]);

            if (cmd.jk_clr)
                jk_reg <= '0;
            else if (cmd.jk_inc)
                jk_reg <= jk_plus1;

            if (cmd.cap)
                kept_reg <= '0;
            else if (cmd.keep)
                kept_reg <= kept_reg + KCW'(1);

            if (cmd.cap)
                over_reg <= load_over_reg;
            else if (cmd.set_over)
                over_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sort_take)
            si_reg <= score_q_reg;
        if (cmd.rd_box_ord)
            cand_idx_reg <= order_q_reg;
        if (cmd.cand_latch)
            cand_reg <= box_q_reg;
    end

    // Overlap geometry between the candidate and the box read from the store.
    always_comb
    begin
        ax0 = cand_reg[63:48];
        ay0 = cand_reg[47:32];
        ax1 = cand_reg[31:16];
        ay1 = cand_reg[15:0];
        bx0 = box_q_reg[63:48];
        by0 = box_q_reg[47:32];
        bx1 = box_q_reg[31:16];
        by1 = box_q_reg[15:0];
        disj = (bx0 > ax1) || (bx1 < ax0) || (by0 > ay1) || (by1 < ay0);
        ix0 = (ax0 > bx0) ? ax0 : bx0;
        iy0 = (ay0 > by0) ? ay0 : by0;
        ix1 = (ax1 < bx1) ? ax1 : bx1;
        iy1 = (ay1 < by1) ? ay1 : by1;
        iw  = {ix1[15], ix1} - {ix0[15], ix0};
        ih  = {iy1[15], iy1} - {iy0[15], iy0};
        b_inv = (bx1 < bx0) || (by1 < by0);
        a_inv = (ax1 < ax0) || (ay1 < ay0);
        bwd = {bx1[15], bx1} - {bx0[15], bx0};
        bhd = {by1[15], by1} - {by0[15], by0};
        awd = {ax1[15], ax1} - {ax0[15], ax0};
        ahd = {ay1[15], ay1} - {ay0[15], ay0};
    end

    // Free-running arithmetic chain; the controller waits for it to settle.
    always_ff @(posedge clk)
    begin
        pass_g_reg <= disj || iw[16] || (iw == 17'sd0) || ih[16] || (ih == 17'sd0);
        iw_reg     <= iw[15:0];
        ih_reg     <= ih[15:0];
        bw_reg     <= b_inv ? 16'd0 : bwd[15:0];
        bh_reg     <= b_inv ? 16'd0 : bhd[15:0];
        area_a_reg <= a_inv ? 32'd0 : awd[15:0] * ahd[15:0];
        inter_reg  <= iw_reg * ih_reg;
        area_b_reg <= bw_reg * bh_reg;
        uni_reg    <= {1'b0, area_a_reg} + {1'b0, area_b_reg} - {1'b0, inter_reg};
        plo_reg    <= ovl_thr_reg * uni_reg[16:0];
        phi_reg    <= ovl_thr_reg * uni_reg[32:17];
    end

    assign lhs = {3'b0, inter_reg, 16'b0};
    assign rhs = {1'b0, phi_reg, 17'b0} + {17'b0, plo_reg};

    // Result register.
    always_ff @(posedge clk)
    begin
        if (cmd.out_none)
        begin
            out_idx_reg   <= '0;
            out_score_reg <= '0;
            out_none_reg  <= 1'b1;
            out_over_reg  <= over_reg;
            out_last_reg  <= 1'b1;
        end
        else if (cmd.out_load)
        begin
            out_idx_reg   <= 10'(kl_q_reg);
            out_score_reg <= score_q_reg;
            out_none_reg  <= 1'b0;
            out_over_reg  <= over_reg;
            out_last_reg  <= (jk_plus1 == kept_reg);
        end
    end

    assign kept_index  = out_idx_reg;
    assign kept_score  = out_score_reg;
    assign none_kept   = out_none_reg;
    assign overflow    = out_over_reg;
    assign last_result = out_last_reg;

    always_comb
    begin
        sts.in_last    = last_box;
        sts.all_loaded = (i_reg == loaded_reg);
        sts.score_pass = ($signed({1'b0, score_q_reg}) > score_thr_reg);
        sts.j_zero     = (j_reg == '0);
        sts.score_less = (score_q_reg < si_reg);
        sts.walk_done  = (i_reg == cc_reg);
        sts.kept_all   = (jk_reg == kept_reg);
        sts.kept_full  = (kept_reg == KCW'(MAX_KEEP));
        sts.pair_ok    = pass_g_reg || (lhs <= rhs);
        sts.kept_zero  = (kept_reg == '0);
        sts.out_last   = out_last_reg;
    end

endmodule

// ----- src/gbos_ctrl.sv -----
// Controller state machine that sequences load, sort, suppression and output.
module gbos_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    input  gbos_pkg::sts_t sts,
    output gbos_pkg::cmd_t cmd
);
    import gbos_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_LOAD;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:      if (in_valid && sts.in_last) state_next = ST_SORT_INIT;
            ST_SORT_INIT: state_next = ST_SORT_CHK;
            ST_SORT_CHK:  state_next = sts.all_loaded ? ST_CAP : ST_SORT_SC;
            ST_SORT_SC:   state_next = sts.score_pass ? ST_SORT_J : ST_SORT_CHK;
            ST_SORT_J:    state_next = sts.j_zero ? ST_SORT_CHK : ST_SORT_RO;
            ST_SORT_RO:   state_next = ST_SORT_RS;
            ST_SORT_RS:   state_next = sts.score_less ? ST_SORT_J : ST_SORT_CHK;
            ST_CAP:       state_next = ST_WALK_CHK;
            ST_WALK_CHK:  state_next = sts.walk_done ? ST_OUT_INIT : ST_WALK_RO;
            ST_WALK_RO:   state_next = ST_WALK_RB;
            ST_WALK_RB:   state_next = ST_WALK_AREA;
            ST_WALK_AREA: state_next = ST_PAIR_CHK;
            ST_PAIR_CHK:
            begin
                if (!sts.kept_all)
                    state_next = ST_PAIR_RK;
                else if (sts.kept_full)
                    state_next = ST_OUT_INIT;
                else
                    state_next = ST_WALK_CHK;
            end
            ST_PAIR_RK:   state_next = ST_PAIR_RB;
            ST_PAIR_RB:   state_next = ST_PAIR_W1;
            ST_PAIR_W1:   state_next = ST_PAIR_W2;
            ST_PAIR_W2:   state_next = ST_PAIR_W3;
            ST_PAIR_W3:   state_next = ST_PAIR_DEC;
            ST_PAIR_DEC:  state_next = sts.pair_ok ? ST_PAIR_CHK : ST_WALK_CHK;
            ST_OUT_INIT:  state_next = sts.kept_zero ? ST_OUT_WAIT : ST_OUT_RK;
            ST_OUT_RK:    state_next = ST_OUT_RS;
            ST_OUT_RS:    state_next = ST_OUT_LD;
            ST_OUT_LD:    state_next = ST_OUT_WAIT;
            ST_OUT_WAIT:
            begin
                if (out_ready)
                    state_next = sts.out_last ? ST_LOAD : ST_OUT_RK;
            end
            default:      state_next = ST_LOAD;
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            ST_LOAD:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_SORT_INIT: cmd.sort_init = 1'b1;
            ST_SORT_CHK:  cmd.rd_score_i = !sts.all_loaded;
            ST_SORT_SC:
            begin
                cmd.sort_take = sts.score_pass;
                cmd.i_inc     = !sts.score_pass;
            end
            ST_SORT_J:
            begin
                cmd.ins_i      = sts.j_zero;
                cmd.rd_ord_jm1 = !sts.j_zero;
            end
            ST_SORT_RO:   cmd.rd_score_ord = 1'b1;
            ST_SORT_RS:
            begin
                // A later equal score stays behind the earlier one.
                cmd.shift = sts.score_less;
                cmd.ins_i = !sts.score_less;
            end
            ST_CAP:       cmd.cap = 1'b1;
            ST_WALK_CHK:  cmd.rd_ord_i = !sts.walk_done;
            ST_WALK_RO:   cmd.rd_box_ord = 1'b1;
            ST_WALK_RB:   cmd.cand_latch = 1'b1;
            ST_WALK_AREA: cmd.jk_clr = 1'b1;
            ST_PAIR_CHK:
            begin
                cmd.rd_kl    = !sts.kept_all;
                cmd.set_over = sts.kept_all && sts.kept_full;
                cmd.keep     = sts.kept_all && !sts.kept_full;
            end
            ST_PAIR_RK:   cmd.rd_box_kl = 1'b1;
            ST_PAIR_RB, ST_PAIR_W1, ST_PAIR_W2, ST_PAIR_W3: ;
            ST_PAIR_DEC:
            begin
                cmd.jk_inc = sts.pair_ok;
                cmd.i_inc  = !sts.pair_ok;
            end
            ST_OUT_INIT:
            begin
                cmd.jk_clr   = 1'b1;
                cmd.out_none = sts.kept_zero;
            end
            ST_OUT_RK:    cmd.rd_kl = 1'b1;
            ST_OUT_RS:    cmd.rd_score_kl = 1'b1;
            ST_OUT_LD:    cmd.out_load = 1'b1;
            ST_OUT_WAIT:
            begin
                out_valid     = 1'b1;
                cmd.clear_run = out_ready && sts.out_last;
                cmd.jk_inc    = out_ready && !sts.out_last;
            end
            default: ;
        endcase
    end

endmodule

// ----- src/greedy_box_overlap_suppression.sv -----
// Top level of the greedy box overlap suppression block.
// Boxes load one per cycle into the stores while the block is in its load state, not
// while a set is sorted, suppressed or still has results pending. After the box marked
// last, the block sorts the candidates by insertion. Suppression then compares each
// candidate with the already kept boxes, waiting for the registered memory reads and
// the multiplier chain of the overlap test. Each result is then read from the stores
// and held until the consumer takes it, and a new set is accepted after the final
// result is taken. Register writes are accepted in every cycle, but they must only be
// issued while no set is in flight.
module greedy_box_overlap_suppression #(
    parameter int MAX_BOXES = gbos_pkg::DEF_MAX_BOXES,
    parameter int MAX_KEEP  = gbos_pkg::DEF_MAX_KEEP
) (
    input logic         clk,
    input logic         rst_n,
    gbos_box_if.sink    box,
    gbos_res_if.source  res,
    gbos_cfg_if.sink    cfg
);
    import gbos_pkg::*;

    cmd_t cmd;
    sts_t sts;

    assign cfg.ready = 1'b1;

    gbos_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (box.valid),
        .in_ready  (box.ready),
        .out_valid (res.valid),
        .out_ready (res.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    gbos_dp #(
        .MAX_BOXES (MAX_BOXES),
        .MAX_KEEP  (MAX_KEEP)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .box_xmin    (box.box_xmin),
        .box_ymin    (box.box_ymin),
        .box_xmax    (box.box_xmax),
        .box_ymax    (box.box_ymax),
        .score       (box.score),
        .last_box    (box.last_box),
        .cfg_wr      (cfg.valid),
        .cfg_index   (cfg.index),
        .cfg_data    (cfg.data),
        .kept_index  (res.kept_index),
        .kept_score  (res.kept_score),
        .none_kept   (res.none_kept),
        .overflow    (res.overflow),
        .last_result (res.last_result)
    );

endmodule
